@@ hw/rtl/sfcp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame parser package
// Frame length, widths and the result record passed from the frame tracker
// to the result register.
// ----------------------------------------------------------------------------
package sfcp_pkg;

	localparam int unsigned FRAME_BYTES = 6;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned READING_W = 16;
	localparam int unsigned POS_W = 3;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h2C;
	localparam logic [POS_W-1:0] POS_IDLE = '0;
	localparam logic [POS_W-1:0] POS_HIGH = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LOW = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	typedef struct packed {
		logic valid;
		logic [READING_W-1:0] reading;
		logic checksum_ok;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/sfcp_frame_fsm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Frame tracker
// Follows the byte position inside a frame, keeps the running sum and the
// two reading bytes, and forms the result on the last byte of a frame.
// ----------------------------------------------------------------------------
module sfcp_frame_fsm (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic advance,
	input  wire logic [sfcp_pkg::BYTE_W-1:0] rx_byte_s1,
	input  wire logic [sfcp_pkg::BYTE_W-1:0] header_q,
	output sfcp_pkg::result_t result
);
	import sfcp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] high_q;
	logic [BYTE_W-1:0] low_q;
	logic last_byte;

	// A position beyond the last byte is treated as the last byte.
	assign last_byte = (pos_q != POS_IDLE) && (pos_q >= POS_LAST);

	always_comb begin
		result.valid = advance && last_byte;
		result.reading = {high_q, low_q};
		result.checksum_ok = (rx_byte_s1 == sum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			sum_q <= '0;
			high_q <= '0;
			low_q <= '0;
		end else if (advance) begin
			if (pos_q == POS_IDLE) begin
				if (rx_byte_s1 == header_q) begin
					sum_q <= rx_byte_s1;
					pos_q <= POS_HIGH;
				end
			end else if (last_byte) begin
				pos_q <= POS_IDLE;
				sum_q <= '0;
			end else begin
				if (pos_q == POS_HIGH) begin
					high_q <= rx_byte_s1;
				end
				if (pos_q == POS_LOW) begin
					low_q <= rx_byte_s1;
				end
				sum_q <= sum_q + rx_byte_s1;
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sfcp_out_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result until the downstream side takes the request.
// ----------------------------------------------------------------------------
module sfcp_out_reg (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sfcp_pkg::result_t result,
	input  wire logic out_ready,
	output logic out_valid,
	output logic [sfcp_pkg::READING_W-1:0] reading,
	output logic checksum_ok
);
	import sfcp_pkg::*;

	logic valid_q;
	logic [READING_W-1:0] reading_q;
	logic ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			reading_q <= result.reading;
			ok_q <= result.checksum_ok;
		end
	end

	assign out_valid = valid_q;
	assign reading = reading_q;
	assign checksum_ok = ok_q;

endmodule
`default_nettype wire

@@ hw/rtl/sensor_frame_checksum_parser_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame checksum parser
// Parses six-byte frames from a received byte stream and reports the reading
// with a checksum flag.
// ----------------------------------------------------------------------------
// The unit takes one received byte per clock cycle. Outside a frame it drops
// every byte until one equals header_value; that byte and the next five form a
// frame, and on the sixth byte one result is given: bytes two and three as a
// big-endian reading, and checksum_ok set when the sixth byte equals the 8-bit
// sum of the first five. Each byte is held in the input register and is
// parsed from there straight into the result register, and a byte can be
// accepted every cycle as long as the result register is free or being read.
// header_value is written through its own port, which is always ready; write
// it only between frames.
module sensor_frame_checksum_parser_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [sfcp_pkg::BYTE_W-1:0] header_value,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [sfcp_pkg::BYTE_W-1:0] rx_byte,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [sfcp_pkg::READING_W-1:0] reading,
	output logic checksum_ok
);
	import sfcp_pkg::*;

	logic [BYTE_W-1:0] header_q;
	logic valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic advance;
	result_t result;

	assign cfg_ready = 1'b1;

	// The held byte moves on whenever the result register can take a new value.
	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_valid) begin
			header_q <= header_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	sfcp_frame_fsm u_frame_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.rx_byte_s1 (rx_byte_s1),
		.header_q   (header_q),
		.result     (result)
	);

	sfcp_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.result      (result),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.reading     (reading),
		.checksum_ok (checksum_ok)
	);

endmodule
`default_nettype wire

@@ hw/rtl/sfcp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame parser checker
// Port-level checks on the handshakes and result timing of the parser.
// ----------------------------------------------------------------------------
module sfcp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [sfcp_pkg::READING_W-1:0] reading,
	input wire logic checksum_ok
);
	import sfcp_pkg::*;

	// A result waiting to be taken must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reading) && $stable(checksum_ok))
		else $error("result changed while stalled");

	// The input side only stalls while a result is waiting to be taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a pending result");

	// A new result follows a byte that passed through the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching byte");

	// Configuration requests are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration request stalled");

endmodule

bind sensor_frame_checksum_parser_unit sfcp_checker u_sfcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.reading     (reading),
	.checksum_ok (checksum_ok)
);
`default_nettype wire
